// ===== design/line_split_wildcard_filter_defines.svh =====
// Assertion macros for the line splitter and glob filter.
// Used by the top level; expects clk and rst_n in scope.
`ifndef LINE_SPLIT_WILDCARD_FILTER_DEFINES_SVH
`define LINE_SPLIT_WILDCARD_FILTER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define LSWF_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lswf assertion failed");

`define LSWF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lswf assertion failed");

`else

`define LSWF_ASSERT_IMPLIES(lbl, ante, cons)

`define LSWF_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== design/lswf_pkg.sv =====
// Shared types and constants for the line splitter and glob filter.
// No dependencies.
`default_nettype none

package lswf_pkg;

    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_LF = 8'h0a;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_RUN  = 2'd1;
    localparam logic [1:0] MODE_ONE  = 2'd2;

    localparam logic [2:0] REG_BODY_LOW  = 3'd0;
    localparam logic [2:0] REG_BODY_HIGH = 3'd1;
    localparam logic [2:0] REG_BODY_LEN  = 3'd2;
    localparam logic [2:0] REG_LEAD_MODE = 3'd3;
    localparam logic [2:0] REG_TRAIL_MODE = 3'd4;

    typedef struct packed {
        logic [31:0] line_number;
        logic [7:0]  line_length;
        logic        line_matches;
    } result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    function automatic logic [1:0] eff_mode(input logic [1:0] m);
        return (m > MODE_ONE) ? MODE_NONE : m;
    endfunction

endpackage

`default_nettype wire

// ===== design/lswf_front.sv =====
// Front end: configuration registers, byte window, line tracking and glob match.
// Depends on lswf_pkg; pushes one result per finished line into the queue.
`default_nettype none

module lswf_front
    import lswf_pkg::*;
#(
    parameter int LINE_MAX = 256,
    parameter int BODY_MAX = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        s_tuser,
    input  wire qstat_t      q_stat,
    output logic             push,
    output result_t          push_entry
);

    localparam int WIN   = BODY_MAX + 1;
    localparam int POS_W = $clog2(LINE_MAX);
    localparam int IDX_W = $clog2(WIN);
    localparam int CMP_W = ((POS_W > 5) ? POS_W : 5) + 1;

    logic [127:0]       body_reg;
    logic [4:0]         blen_reg;
    logic [1:0]         lead_reg;
    logic [1:0]         trail_reg;

    logic [WIN*8-1:0]   win_reg;
    logic [POS_W-1:0]   pos_reg;
    logic               seen_reg;
    logic [31:0]        count_reg;

    logic               accept;
    logic               is_term;
    logic               shift;
    logic               endl;
    logic               cut;
    logic               emit;
    logic [WIN*8-1:0]   win_shift;
    logic [WIN*8-1:0]   win_eff;
    logic [POS_W-1:0]   pos_next;
    logic               seen_next;
    logic [31:0]        count_next;
    logic [4:0]         eff_blen;
    logic [CMP_W-1:0]   pos_x;
    logic [CMP_W-1:0]   bl_x;
    logic               hit0;
    logic               hit1;
    logic               line_hit;
    logic [1:0]         lead_eff;
    logic [1:0]         trail_eff;

    function automatic logic win_hit(input logic [WIN*8-1:0] w, input logic d,
                                     input logic [4:0] bl);
        logic             ok;
        logic [IDX_W-1:0] idx;
        ok  = 1'b1;
        idx = '0;
        for (int k = 0; k < BODY_MAX; k++)
        begin
            if (k < int'(bl))
            begin
                idx = IDX_W'(int'(d) + int'(bl) - 1 - k);
                if (w[8*idx +: 8] != body_reg[8*k +: 8])
                begin
                    ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

    function automatic logic start_ok(input logic [CMP_W-1:0] s, input logic [1:0] lm);
        logic r;
        unique case (lm)
            MODE_NONE: r = (s == '0);
            MODE_ONE:  r = (s == CMP_W'(1));
            MODE_RUN:  r = 1'b1;
            default:   r = (s == '0);
        endcase
        return r;
    endfunction

    always_comb
    begin
        accept     = s_tvalid && s_tready;
        is_term    = (s_tdata == CH_CR) || (s_tdata == CH_LF);
        shift      = accept && !s_tuser && !is_term;
        win_shift  = {win_reg[(WIN-1)*8-1:0], s_tdata};
        win_eff    = shift ? win_shift : win_reg;
        pos_next   = shift ? pos_reg + POS_W'(1) : pos_reg;
        eff_blen   = (blen_reg > 5'(BODY_MAX)) ? 5'(BODY_MAX) : blen_reg;
        lead_eff   = eff_mode(lead_reg);
        trail_eff  = eff_mode(trail_reg);
        pos_x      = CMP_W'(pos_next);
        bl_x       = CMP_W'(eff_blen);
        hit0       = win_hit(win_eff, 1'b0, eff_blen);
        hit1       = win_hit(win_eff, 1'b1, eff_blen);
        seen_next  = seen_reg || (shift && (eff_blen != 5'd0) && (pos_x >= bl_x)
                     && start_ok(pos_x - bl_x, lead_eff) && hit0);
        cut        = shift && (pos_next == POS_W'(LINE_MAX - 1));
        endl       = accept && (s_tuser || is_term) && (pos_reg != '0);
        emit       = cut || endl;
        count_next = count_reg + 32'd1;

        unique case (trail_eff)
            MODE_NONE: line_hit = (pos_x >= bl_x) && start_ok(pos_x - bl_x, lead_eff) && hit0;
            MODE_ONE:  line_hit = (pos_x >= bl_x + CMP_W'(1))
                                  && start_ok(pos_x - bl_x - CMP_W'(1), lead_eff) && hit1;
            MODE_RUN:  line_hit = seen_next || (eff_blen == 5'd0);
            default:   line_hit = (pos_x >= bl_x) && start_ok(pos_x - bl_x, lead_eff) && hit0;
        endcase

        s_tready                = !q_stat.full;
        push                    = emit;
        push_entry.line_number  = count_next;
        push_entry.line_length  = 8'(pos_next);
        push_entry.line_matches = line_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_reg  <= '0;
            blen_reg  <= 5'd1;
            lead_reg  <= MODE_NONE;
            trail_reg <= MODE_NONE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BODY_LOW:   body_reg[63:0]   <= cfg_data;
                REG_BODY_HIGH:  body_reg[127:64] <= cfg_data;
                REG_BODY_LEN:   blen_reg         <= cfg_data[4:0];
                REG_LEAD_MODE:  lead_reg         <= cfg_data[1:0];
                REG_TRAIL_MODE: trail_reg        <= cfg_data[1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg   <= '0;
            pos_reg   <= '0;
            seen_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (emit)
        begin
            win_reg   <= '0;
            pos_reg   <= '0;
            seen_reg  <= 1'b0;
            count_reg <= count_next;
        end
        else if (shift)
        begin
            win_reg  <= win_shift;
            pos_reg  <= pos_next;
            seen_reg <= seen_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/lswf_queue.sv =====
// Short result queue between the front end and the output stage.
// Depends on lswf_pkg for the entry and status types.
`default_nettype none

module lswf_queue
    import lswf_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_entry,
    input  wire logic    pop,
    output result_t      head,
    output qstat_t       q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t          mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    always_comb
    begin
        q_stat.full  = (count_reg == CNT_W'(DEPTH));
        q_stat.empty = (count_reg == '0);
        do_push      = push && !q_stat.full;
        do_pop       = pop && !q_stat.empty;
        head         = mem_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/lswf_back.sv =====
// Output stage: registers one result and drives the master-side stream.
// Depends on lswf_pkg; pulls entries from lswf_queue.
`default_nettype none

module lswf_back
    import lswf_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire result_t head,
    input  wire qstat_t  q_stat,
    output logic         pop,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    output logic [39:0]  m_tdata,
    output logic         m_tuser
);

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_data_reg;

    always_comb
    begin
        pop            = !q_stat.empty && (!out_valid_reg || m_tready);
        out_valid_next = pop || (out_valid_reg && !m_tready);
        m_tvalid       = out_valid_reg;
        m_tdata        = {out_data_reg.line_number, out_data_reg.line_length};
        m_tuser        = out_data_reg.line_matches;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= head;
        end
    end

endmodule

`default_nettype wire

// ===== design/line_split_wildcard_filter.sv =====
// Top level of the line splitter with restricted glob filter.
// Depends on lswf_pkg, lswf_front, lswf_queue, lswf_back and the defines header.
//
// Usage:
//   Slave stream takes one text byte per request (tdata) with an end-of-input
//   flag (tuser). CR or LF ends a line, empty lines are dropped, and a line
//   reaching LINE_MAX-1 bytes is cut and reported at once.
//   Master stream gives one request per finished line: line length and line
//   number in tdata, match flag in tuser.
//   Throughput: one byte per cycle while s_tready is high; the window compare is done in
//   parallel in the front end, so every byte is classified in the cycle it is accepted.
//   A result passes through the queue and then the output register before it is
//   presented on the master side.
//   Reset clears the byte window, line count and pattern (body length 1,
//   no wildcards); the block is ready as soon as reset is released.
//   When the receiver stalls, results collect in a QUEUE_DEPTH queue plus
//   the output register; s_tready drops only once that queue is full.
//   Configuration writes land on the edge where cfg_we is high; write only
//   while no line result is still outstanding.
`include "line_split_wildcard_filter_defines.svh"
`default_nettype none

module line_split_wildcard_filter
    import lswf_pkg::*;
#(
    parameter int LINE_MAX    = 256,
    parameter int BODY_MAX    = 16,
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] end_of_input
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [7:0] line_length, [39:8] line_number
    output logic             m_tuser    // [0] line_matches
);

    logic    push;
    logic    pop;
    result_t push_entry;
    result_t head;
    qstat_t  q_stat;

    lswf_front #(
        .LINE_MAX (LINE_MAX),
        .BODY_MAX (BODY_MAX)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    lswf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    lswf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    `LSWF_ASSERT_IMPLIES(a_full_has_output, q_stat.full, m_tvalid)
    `LSWF_ASSERT_NEXT(a_output_loads, (!q_stat.empty && !m_tvalid), m_tvalid)
    `LSWF_ASSERT_IMPLIES(a_length_nonzero, ((LINE_MAX <= 256) && m_tvalid), (m_tdata[7:0] != 8'd0))

endmodule

`default_nettype wire

// ===== bench/line_split_wildcard_filter_tb.sv =====
// Self-checking bench for line_split_wildcard_filter: directed and random text
// streams, predicted line results compared on the master stream.
// Depends on lswf_pkg and the line_split_wildcard_filter top level.
`timescale 1ns / 100ps

module line_split_wildcard_filter_tb;
    import lswf_pkg::*;

    localparam int LINE_MAX    = 256;
    localparam int WINDOW_TOP  = 16;
    localparam int STALL_LIMIT = 5000;
    localparam int REPORT_MAX  = 10;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = REG_BODY_LOW;
    logic [63:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;

    // pattern copy
    logic [63:0] pat_low;
    logic [63:0] pat_high;
    logic [4:0]  pat_len;
    logic [1:0]  lead_sel;
    logic [1:0]  trail_sel;

    // line state copy
    logic [7:0]  window_bytes [0:WINDOW_TOP];
    int          pending_len;
    bit          body_found;
    logic [31:0] emitted_count;

    result_t     expected_lines [$];
    result_t     want;

    int send_idle_pct;
    int stall_pct;
    int faults;
    int bytes_sent;
    int lines_checked;
    int patterns_set;
    int idle_cycles;

    line_split_wildcard_filter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic int body_span();
        return (pat_len > WINDOW_TOP) ? WINDOW_TOP : int'(pat_len);
    endfunction

    function automatic logic [7:0] pattern_char(input int k);
        return (k < 8) ? pat_low[8*k +: 8] : pat_high[8*(k-8) +: 8];
    endfunction

    function automatic bit start_allowed(input int s);
        if (lead_sel == MODE_RUN)
        begin
            return 1'b1;
        end
        if (lead_sel == MODE_ONE)
        begin
            return s == 1;
        end
        return s == 0;
    endfunction

    function automatic bit body_ends_at(input int d, input int bl);
        int idx;
        for (int k = 0; k < bl; k++)
        begin
            idx = d + bl - 1 - k;
            if (idx > WINDOW_TOP || window_bytes[idx] != pattern_char(k))
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic bit placed_at(input int d);
        int bl;
        bl = body_span();
        if (pending_len < d + bl)
        begin
            return 1'b0;
        end
        return start_allowed(pending_len - d - bl) && body_ends_at(d, bl);
    endfunction

    task automatic split_and_match(input logic [7:0] b, input logic eoi);
        bit      finish;
        bit      hit;
        int      bl;
        result_t line;
        finish = 1'b0;
        bl     = body_span();
        if (eoi || b == CH_CR || b == CH_LF)
        begin
            finish = pending_len > 0;
        end
        else
        begin
            for (int k = WINDOW_TOP; k > 0; k--)
            begin
                window_bytes[k] = window_bytes[k-1];
            end
            window_bytes[0] = b;
            pending_len++;
            if (bl > 0 && pending_len >= bl && start_allowed(pending_len - bl)
                && body_ends_at(0, bl))
            begin
                body_found = 1'b1;
            end
            finish = pending_len >= LINE_MAX - 1;
        end
        if (finish)
        begin
            if (trail_sel == MODE_RUN)
            begin
                hit = body_found || bl == 0;
            end
            else if (trail_sel == MODE_ONE)
            begin
                hit = placed_at(1);
            end
            else
            begin
                hit = placed_at(0);
            end
            emitted_count++;
            line.line_number  = emitted_count;
            line.line_length  = pending_len[7:0];
            line.line_matches = hit;
            expected_lines.push_back(line);
            foreach (window_bytes[k])
            begin
                window_bytes[k] = 8'h00;
            end
            pending_len = 0;
            body_found  = 1'b0;
        end
    endtask

    // ---------------------------------------------------------------- checking

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            lines_checked++;
            if (expected_lines.size() == 0)
            begin
                if (faults < REPORT_MAX)
                begin
                    $display("%0t: unexpected line result tdata=%h tuser=%b",
                             $realtime, m_tdata, m_tuser);
                end
                faults++;
            end
            else
            begin
                want = expected_lines.pop_front();
                if (m_tdata[7:0] !== want.line_length || m_tdata[39:8] !== want.line_number
                    || m_tuser !== want.line_matches)
                begin
                    if (faults < REPORT_MAX)
                    begin
                        $display("%0t: line %0d expected len=%0d match=%b, got num=%0d len=%0d match=%b",
                                 $realtime, want.line_number, want.line_length,
                                 want.line_matches, m_tdata[39:8], m_tdata[7:0], m_tuser);
                    end
                    faults++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no request moved for %0d cycles, %0d lines outstanding",
                         idle_cycles, expected_lines.size());
                $display("[line_split_wildcard_filter] ERROR");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic push(input logic [7:0] b, input logic eoi);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= eoi;
        do
            @(posedge clk);
        while (!s_tready);
        split_and_match(b, eoi);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_lines.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
    endtask

    task automatic set_pattern(input logic [63:0] lo, input logic [63:0] hi,
                               input logic [63:0] len_w, input logic [63:0] lead_w,
                               input logic [63:0] trail_w);
        settle();
        write_reg(REG_BODY_LOW, lo);
        write_reg(REG_BODY_HIGH, hi);
        write_reg(REG_BODY_LEN, len_w);
        write_reg(REG_LEAD_MODE, lead_w);
        write_reg(REG_TRAIL_MODE, trail_w);
        cfg_we    <= 1'b0;
        pat_low   = lo;
        pat_high  = hi;
        pat_len   = len_w[4:0];
        lead_sel  = lead_w[1:0];
        trail_sel = trail_w[1:0];
        patterns_set++;
    endtask

    function automatic logic [7:0] pick_text();
        logic [7:0] c;
        if ($urandom_range(0, 3) != 0)
        begin
            c = 8'(8'h61 + $urandom_range(0, 3));
        end
        else
        begin
            c = 8'($urandom_range(0, 255));
        end
        if (c == CH_CR || c == CH_LF)
        begin
            c = 8'h65;
        end
        return c;
    endfunction

    function automatic logic [63:0] random_word();
        return {$urandom, $urandom};
    endfunction

    task automatic random_body(output logic [63:0] lo, output logic [63:0] hi);
        for (int k = 0; k < 8; k++)
        begin
            lo[8*k +: 8] = pick_text();
            hi[8*k +: 8] = pick_text();
        end
    endtask

    function automatic int wildcard_span(input logic [1:0] mode, input bit skew);
        if (skew)
        begin
            return $urandom_range(0, 3);
        end
        if (mode == MODE_RUN)
        begin
            return $urandom_range(0, 4);
        end
        return (mode == MODE_ONE) ? 1 : 0;
    endfunction

    task automatic send_random_line();
        logic [7:0] line_bytes [$];
        int         kind;
        int         pre;
        int         suf;
        kind = $urandom_range(0, 9);
        if (kind == 9)
        begin
            repeat ($urandom_range(1, 20)) line_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            pre = wildcard_span(lead_sel, kind >= 6 && kind < 8);
            suf = wildcard_span(trail_sel, kind >= 6 && kind < 8);
            repeat (pre) line_bytes.push_back(pick_text());
            for (int k = 0; k < body_span(); k++)
            begin
                line_bytes.push_back(pattern_char(k));
            end
            repeat (suf) line_bytes.push_back(pick_text());
            if (kind == 8 && line_bytes.size() > 0)
            begin
                line_bytes[$urandom_range(0, line_bytes.size() - 1)] = pick_text();
            end
        end
        foreach (line_bytes[k])
        begin
            push(line_bytes[k], 1'b0);
        end
        case ($urandom_range(0, 5))
            0: push(CH_CR, 1'b0);
            1: push(CH_LF, 1'b0);
            2:
            begin
                push(CH_CR, 1'b0);
                push(CH_LF, 1'b0);
            end
            3:
            begin
                push(CH_LF, 1'b0);
                push(CH_CR, 1'b0);
            end
            4: push(8'($urandom_range(0, 255)), 1'b1);
            default:
            begin
                push(CH_CR, 1'b0);
                push(8'($urandom_range(0, 255)), 1'b1);
            end
        endcase
    endtask

    // ---------------------------------------------------------------- tests

    task automatic check_reset_pattern();
        push(8'h00, 1'b0);
        push(CH_LF, 1'b0);
        push(8'hff, 1'b0);
        push(CH_CR, 1'b0);
        push(CH_LF, 1'b0);
    endtask

    task automatic check_wildcard_modes();
        set_pattern(64'h6261, 64'h0, 64'd2, 64'(MODE_RUN), 64'(MODE_ONE));
        push("x", 1'b0);
        push("x", 1'b0);
        push("a", 1'b0);
        push("b", 1'b0);
        push("z", 1'b0);
        push(CH_CR, 1'b0);
        set_pattern(64'h6261, 64'h0, 64'd2, 64'(MODE_ONE), 64'(MODE_RUN));
        push("x", 1'b0);
        push("a", 1'b0);
        push("b", 1'b0);
        push(CH_CR, 1'b1);
        set_pattern(64'h6261, 64'h0, 64'd2, 64'(MODE_SPARE), 64'(MODE_SPARE));
        push("a", 1'b0);
        push("b", 1'b0);
        push(CH_LF, 1'b0);
        set_pattern(64'h0, 64'h0, 64'd0, 64'(MODE_ONE), 64'(MODE_ONE));
        push("x", 1'b0);
        push("y", 1'b0);
        push(CH_LF, 1'b0);
    endtask

    task automatic check_end_of_input();
        push(8'h41, 1'b1);
        push("q", 1'b0);
        push(CH_LF, 1'b1);
    endtask

    task automatic check_midline_reconfig();
        set_pattern(64'h71, 64'h0, 64'd1, 64'(MODE_RUN), 64'(MODE_RUN));
        push("q", 1'b0);
        set_pattern(64'h7a, 64'h0, 64'd1, 64'(MODE_RUN), 64'(MODE_RUN));
        push("x", 1'b0);
        push(CH_LF, 1'b0);
    endtask

    task automatic check_line_cut();
        set_pattern(64'h7a7a, 64'h0, 64'd2, 64'(MODE_RUN), 64'(MODE_NONE));
        repeat (LINE_MAX - 3) push(pick_text(), 1'b0);
        push("z", 1'b0);
        push("z", 1'b0);
        repeat (10) push(pick_text(), 1'b0);
        push(CH_LF, 1'b0);
    endtask

    task automatic run_random_text(input int regime);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] w;
        logic [4:0]  len;
        logic [1:0]  lead;
        logic [1:0]  trail;
        int          stop;
        int          pick;
        case (regime)
            0: begin send_idle_pct = 0;  stall_pct = 0;  len = 5'd16; lead = MODE_RUN;
                     trail = MODE_RUN; end
            1: begin send_idle_pct = 64; stall_pct = 0;  len = 5'd31; lead = MODE_NONE;
                     trail = MODE_ONE; end
            2: begin send_idle_pct = 0;  stall_pct = 64; len = 5'd0;  lead = MODE_ONE;
                     trail = MODE_RUN; end
            default:
            begin
                send_idle_pct = 34;
                stall_pct     = 34;
                len           = 5'($urandom_range(1, 16));
                lead          = MODE_SPARE;
                trail         = MODE_SPARE;
            end
        endcase
        random_body(lo, hi);
        w = random_word();
        set_pattern(lo, hi, {w[63:5], len}, {w[63:2], lead}, {w[63:2], trail});
        stop = bytes_sent + 85;
        while (bytes_sent < stop)
        begin
            send_random_line();
        end

        random_body(lo, hi);
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            len = 5'd0;
        end
        else if (pick == 1)
        begin
            len = 5'($urandom_range(17, 31));
        end
        else if (pick == 2)
        begin
            len = 5'd16;
        end
        else
        begin
            len = 5'($urandom_range(1, 6));
        end
        lead  = 2'($urandom_range(0, 3));
        trail = 2'($urandom_range(0, 3));
        w = random_word();
        set_pattern(lo, hi, {w[63:5], len}, {w[63:2], lead}, {w[63:2], trail});
        stop = bytes_sent + 85;
        while (bytes_sent < stop)
        begin
            send_random_line();
        end
        settle();
    endtask

    initial
    begin
        pat_low       = '0;
        pat_high      = '0;
        pat_len       = 5'd1;
        lead_sel      = MODE_NONE;
        trail_sel     = MODE_NONE;
        pending_len   = 0;
        body_found    = 1'b0;
        emitted_count = '0;
        foreach (window_bytes[k])
        begin
            window_bytes[k] = 8'h00;
        end
        send_idle_pct = 0;
        stall_pct     = 0;
        faults        = 0;
        bytes_sent    = 0;
        lines_checked = 0;
        patterns_set  = 0;
        idle_cycles   = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        check_reset_pattern();
        check_wildcard_modes();
        check_end_of_input();
        check_midline_reconfig();
        check_line_cut();
        for (int regime = 0; regime < 4; regime++)
        begin
            run_random_text(regime);
        end
        settle();
        repeat (8) @(negedge clk);

        $display("%0d text bytes sent, %0d line results checked, %0d pattern settings,",
                 bytes_sent, lines_checked, patterns_set);
        $display("free-running, sender-gapped, receiver-stalled and mixed handshake phases");
        if (faults == 0 && expected_lines.size() == 0)
        begin
            $display("[line_split_wildcard_filter] OK");
        end
        else
        begin
            $display("[line_split_wildcard_filter] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/lswf_pkg.sv
design/lswf_front.sv
design/lswf_queue.sv
design/lswf_back.sv
design/line_split_wildcard_filter.sv
bench/line_split_wildcard_filter_tb.sv
